// ----- src/indexed_list_insert_remove_macros.svh -----
// Assertion macros shared by the list design.
`ifndef INDEXED_LIST_INSERT_REMOVE_MACROS_SVH
`define INDEXED_LIST_INSERT_REMOVE_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define ILIR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list assertion failed");

// Next-cycle implication, checked outside of reset.
`define ILIR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list assertion failed");

`endif

// ----- src/ilir_pkg.sv -----
package ilir_pkg;

    localparam int CAPACITY   = 64;
    localparam int ENTRY_BITS = 8;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int POS_BITS   = 7;
    localparam int MODE_BITS  = 3;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_PUSH      = 3'd0,
        MODE_INSERT    = 3'd1,
        MODE_POP       = 3'd2,
        MODE_REMOVE    = 3'd3,
        MODE_READ      = 3'd4,
        MODE_OVERWRITE = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_WRITE
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [POS_BITS-1:0]   pos;
        logic [ENTRY_BITS-1:0] data;
    } ilir_ctrl_t;

endpackage

// ----- src/ilir_cell.sv -----
module ilir_cell
    import ilir_pkg::*;
(
    input  logic                  clk,
    input  logic [IDX_BITS-1:0]   idx,
    input  ilir_ctrl_t            ctrl,
    input  logic [ENTRY_BITS-1:0] lower,
    input  logic [ENTRY_BITS-1:0] upper,
    output logic [ENTRY_BITS-1:0] entry,
    output logic [ENTRY_BITS-1:0] rd_data
);

    logic [ENTRY_BITS-1:0] entry_reg;
    logic [ENTRY_BITS-1:0] entry_next;
    logic [POS_BITS-1:0]   my_pos;
    logic                  at_pos;
    logic                  above_pos;

    assign my_pos    = POS_BITS'(idx);
    assign at_pos    = (my_pos == ctrl.pos);
    assign above_pos = (my_pos > ctrl.pos);

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            CELL_INSERT:
            begin
                if (at_pos)
                begin
                    entry_next = ctrl.data;
                end
                else if (above_pos)
                begin
                    entry_next = lower;
                end
            end
            CELL_REMOVE:
            begin
                if (at_pos || above_pos)
                begin
                    entry_next = upper;
                end
            end
            CELL_WRITE:
            begin
                if (at_pos)
                begin
                    entry_next = ctrl.data;
                end
            end
            CELL_HOLD:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry   = entry_reg;
    assign rd_data = at_pos ? entry_reg : '0;

endmodule

// ----- src/indexed_list_insert_remove.sv -----
// A response is valid in the cycle after its request is accepted.
// Throughput: one request per cycle unless responses stall; the cell row
// shifts entries at and above the position; the response register
// decouples the two sides. A new request is accepted while the held
// response is being taken. Reset clears the count and the response
// valid; entry contents are undefined until written.
`include "indexed_list_insert_remove_macros.svh"

module indexed_list_insert_remove
    import ilir_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic [MODE_BITS-1:0]  mode,
    input  logic [POS_BITS-1:0]   position,
    input  logic [ENTRY_BITS-1:0] entry_in,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output logic                  status,
    output logic [ENTRY_BITS-1:0] entry_out,
    output logic [COUNT_BITS-1:0] count_out
);

    localparam logic [COUNT_BITS-1:0] CAP = COUNT_BITS'(CAPACITY);

    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  rsp_valid_reg;
    logic                  status_reg;
    logic [ENTRY_BITS-1:0] entry_out_reg;
    logic [COUNT_BITS-1:0] count_out_reg;

    logic                  fire;
    logic                  err;
    logic                  takes_entry;
    logic [POS_BITS-1:0]   eff_pos;
    logic [POS_BITS-1:0]   count_pos;
    cell_op_t              op;
    ilir_ctrl_t            ctrl;
    logic [ENTRY_BITS-1:0] rd_any;

    logic [ENTRY_BITS-1:0] cell_entry [CAPACITY];
    logic [ENTRY_BITS-1:0] cell_rd    [CAPACITY];

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign fire      = req_valid && req_ready;
    assign count_pos = POS_BITS'(count_reg);

    always_comb
    begin
        err         = 1'b0;
        takes_entry = 1'b0;
        op          = CELL_HOLD;
        eff_pos     = position;
        count_next  = count_reg;
        unique case (mode)
            MODE_PUSH:
            begin
                eff_pos = count_pos;
                err     = (count_reg >= CAP);
                op      = CELL_INSERT;
                if (!err)
                begin
                    count_next = count_reg + COUNT_BITS'(1);
                end
            end
            MODE_INSERT:
            begin
                err = (position > count_pos) || (count_reg >= CAP);
                op  = CELL_INSERT;
                if (!err)
                begin
                    count_next = count_reg + COUNT_BITS'(1);
                end
            end
            MODE_POP:
            begin
                eff_pos     = count_pos - POS_BITS'(1);
                err         = (count_reg == '0);
                op          = CELL_REMOVE;
                takes_entry = 1'b1;
                if (!err)
                begin
                    count_next = count_reg - COUNT_BITS'(1);
                end
            end
            MODE_REMOVE:
            begin
                err         = (position >= count_pos);
                op          = CELL_REMOVE;
                takes_entry = 1'b1;
                if (!err)
                begin
                    count_next = count_reg - COUNT_BITS'(1);
                end
            end
            MODE_READ:
            begin
                err         = (position >= count_pos);
                takes_entry = 1'b1;
            end
            MODE_OVERWRITE:
            begin
                err = (position >= count_pos);
                op  = CELL_WRITE;
            end
            default:
            begin
                err = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        ctrl.op   = (fire && !err) ? op : CELL_HOLD;
        ctrl.pos  = eff_pos;
        ctrl.data = entry_in;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ENTRY_BITS-1:0] lower;
        logic [ENTRY_BITS-1:0] upper;

        if (i == 0)
        begin : g_first
            assign lower = '0;
        end
        else
        begin : g_mid_lo
            assign lower = cell_entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign upper = '0;
        end
        else
        begin : g_mid_hi
            assign upper = cell_entry[i+1];
        end

        ilir_cell u_cell (
            .clk     (clk),
            .idx     (IDX_BITS'(i)),
            .ctrl    (ctrl),
            .lower   (lower),
            .upper   (upper),
            .entry   (cell_entry[i]),
            .rd_data (cell_rd[i])
        );
    end

    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_any = rd_any | cell_rd[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg    <= err;
            entry_out_reg <= (err || !takes_entry) ? '0 : rd_any;
            count_out_reg <= count_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign entry_out = entry_out_reg;
    assign count_out = count_out_reg;

    `ILIR_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CAP)
    `ILIR_ASSERT_NEXT(a_err_keeps_count, fire && err, count_reg == $past(count_reg))
    `ILIR_ASSERT_NEXT(a_err_zero_entry, fire && err, status && entry_out == '0)
    `ILIR_ASSERT_NEXT(a_insert_grows, fire && !err && op == CELL_INSERT,
                      count_reg == $past(count_reg) + COUNT_BITS'(1))
    `ILIR_ASSERT_NEXT(a_rsp_count, fire, count_out == count_reg)

endmodule
